[rtl/fpfl_pkg.sv]
// Shared types and constants of the fixed-size pool allocator.
// Request and status codes, field widths and register indexes.
// No dependencies.
package fpfl_pkg;

  // payload widths fixed by the register and field map
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;
  localparam int CNT_W  = 11;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_OBJECT_SIZE = 2'd1;
  localparam logic [1:0] REG_NUM_OBJECTS = 2'd2;

  // request kinds
  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_INIT  = 2'd3
  } kind_t;

  // result status
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SIZE   = 3'd1,
    ST_NOMEM  = 3'd2,
    ST_BADPTR = 3'd3,
    ST_FREE   = 3'd4
  } status_t;

endpackage

[rtl/fpfl_req_if.sv]
// Request channel of the pool allocator: valid/ready plus request payload.
// Depends on fpfl_pkg.
interface fpfl_req_if import fpfl_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] address;

  modport source (output valid, kind, request_size, address, input ready);
  modport sink   (input valid, kind, request_size, address, output ready);
endinterface

[rtl/fpfl_rsp_if.sv]
// Result channel of the pool allocator: valid/ready plus status and address.
// Depends on fpfl_pkg.
interface fpfl_rsp_if import fpfl_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ADDR_W-1:0] object_address;

  modport source (output valid, status, object_address, input ready);
  modport sink   (input valid, status, object_address, output ready);
endinterface

[rtl/fpfl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fpfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/fixed_pool_free_list_allocator.sv]
// Fixed-size object pool allocator with a linked free list in one RAM.
// One request is in flight at a time; the next is taken from the edge that raises out valid.
// Allocate: list top read, then pop; a size or empty error goes straight to emit. Free: range
// check, IW = clog2(MAX_OBJECTS) divider steps, then push; a bad address ends early. Check: the
// same, then a walk of up to MAX_OBJECTS list entries. Init: one write per clamped object.
// Emit stalls while a result waits. Reset: config defaults, list empty; RAM not cleared.
module fixed_pool_free_list_allocator import fpfl_pkg::*; #(
  parameter int MAX_OBJECTS = 1024,
  parameter int ENTRY_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  fpfl_req_if.sink          in_req,
  fpfl_rsp_if.source        out_rsp,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int IW  = $clog2(MAX_OBJECTS);              // entry index
  localparam int CW  = $clog2(MAX_OBJECTS + 1);          // object count
  localparam int NW  = (CNT_W > CW) ? CNT_W : CW;        // clamp compare
  localparam int SW  = SIZE_W + CW;                      // pool span
  localparam int LW  = (ADDR_W > SW) ? ADDR_W : SW;      // span compare
  localparam int PW  = SIZE_W + IW;                      // index * size
  localparam int DW  = (ADDR_W > PW) ? ADDR_W : PW;      // divider datapath
  localparam int BW  = $clog2(IW + 1);                   // divider step count
  localparam int RS  = 24;                               // reciprocal scale
  localparam int PRW = SIZE_W + RS + 1;                  // size * reciprocal
  localparam longint unsigned RECIP =
    ((64'd1 << RS) + 64'(ENTRY_BYTES) - 64'd1) / 64'(ENTRY_BYTES);

  typedef struct packed {
    logic          last;
    logic [IW-1:0] idx;
  } link_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_LOC, S_DIV, S_DIVEND, S_WALK, S_WSTEP, S_IMOD, S_IFILL, S_EMIT
  } state_t;

  // ---------------------------------------------------------------
  // configuration registers
  logic [ADDR_W-1:0] pool_base_r;
  logic [SIZE_W-1:0] object_size_r;
  logic [CNT_W-1:0]  num_objects_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      object_size_r <= SIZE_W'(4);
      num_objects_r <= CNT_W'(1024);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_POOL_BASE:   pool_base_r   <= cfg_pwdata[ADDR_W-1:0];
        REG_OBJECT_SIZE: object_size_r <= cfg_pwdata[SIZE_W-1:0];
        REG_NUM_OBJECTS: num_objects_r <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_POOL_BASE:   cfg_prdata = CFG_DW'(pool_base_r);
      REG_OBJECT_SIZE: cfg_prdata = CFG_DW'(object_size_r);
      REG_NUM_OBJECTS: cfg_prdata = CFG_DW'(num_objects_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // object count clamped to the pool depth
  logic [NW-1:0] num_ext;
  logic [CW-1:0] eff_cnt;

  assign num_ext = NW'(num_objects_r);
  assign eff_cnt = (num_ext > NW'(MAX_OBJECTS)) ? CW'(MAX_OBJECTS) : CW'(num_ext);

  // ---------------------------------------------------------------
  // free list RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  link_t         ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  link_t         rd_link;

  fpfl_ram #(
    .WIDTH ($bits(link_t)),
    .DEPTH (MAX_OBJECTS)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_link)
  );

  // ---------------------------------------------------------------
  // control state and datapath registers
  state_t            state_r;
  kind_t             kind_r;
  logic [IW-1:0]     head_r;
  logic              head_valid_r;
  logic [PW-1:0]     prod_r;
  logic [ADDR_W-1:0] off_r;
  logic              below_r;
  logic [SW-1:0]     span_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     div_r;
  logic [IW-1:0]     q_r;
  logic [BW-1:0]     cnt_r;
  logic [IW-1:0]     cur_r;
  logic              live_r;
  logic [CW-1:0]     steps_r;
  logic [CW-1:0]     fill_r;
  status_t           res_status_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic              in_acc;
  logic              alloc_go;
  logic              div_ge;
  logic [DW-1:0]     rem_nxt;
  logic [IW:0]       q_shift;
  logic [PRW-1:0]    size_prod;
  logic [SIZE_W-1:0] size_quot;
  logic [SIZE_W-1:0] size_res;
  logic [CW-1:0]     fill_inc;
  logic              fill_last;
  logic              out_free;
  logic              bad_span;

  assign in_req.ready   = (state_r == S_IDLE);
  assign in_acc         = in_req.valid && in_req.ready;
  assign alloc_go       = (in_req.request_size == object_size_r) && head_valid_r;

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.object_address = out_addr_r;
  assign out_free               = !out_valid_r || out_rsp.ready;

  // restoring divider step
  assign div_ge  = (rem_r >= div_r);
  assign rem_nxt = div_ge ? (rem_r - div_r) : rem_r;
  assign q_shift = {q_r, div_ge};

  // address range check against the pool span
  assign bad_span = below_r || (LW'(off_r) >= LW'(span_r));

  // object size modulo entry size, quotient by reciprocal multiply
  assign size_prod = PRW'(object_size_r) * PRW'(RECIP);
  assign size_quot = size_prod[SIZE_W+RS-1:RS];
  assign size_res  = object_size_r - size_quot * SIZE_W'(ENTRY_BYTES);

  // init chaining
  assign fill_inc  = fill_r + CW'(1);
  assign fill_last = (fill_inc == eff_cnt);

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        // read the list top for an allocate that will succeed
        if (in_acc && (in_req.kind == KIND_ALLOC) && alloc_go) begin
          ram_re    = 1'b1;
          ram_raddr = head_r;
        end
      end
      S_DIVEND: begin
        // push the freed entry
        if ((kind_r == KIND_FREE) && (rem_r == '0)) begin
          ram_we         = 1'b1;
          ram_waddr      = q_r;
          ram_wdata.last = !head_valid_r;
          ram_wdata.idx  = head_r;
        end
      end
      S_WALK: begin
        if (live_r && (steps_r != CW'(MAX_OBJECTS)) && (cur_r != q_r)) begin
          ram_re    = 1'b1;
          ram_raddr = cur_r;
        end
      end
      S_IFILL: begin
        ram_we         = 1'b1;
        ram_waddr      = fill_r[IW-1:0];
        ram_wdata.last = fill_last;
        ram_wdata.idx  = fill_inc[IW-1:0];
      end
      default: ;
    endcase
  end

  // sequencer, list head and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      head_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_rsp.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            kind_r     <= in_req.kind;
            res_addr_r <= '0;
            off_r      <= in_req.address - pool_base_r;
            below_r    <= in_req.address < pool_base_r;
            span_r     <= SW'(object_size_r) * SW'(eff_cnt);
            prod_r     <= PW'(head_r) * PW'(object_size_r);
            unique case (in_req.kind)
              KIND_ALLOC: begin
                if (in_req.request_size != object_size_r) begin
                  res_status_r <= ST_SIZE;
                  state_r      <= S_EMIT;
                end else if (!head_valid_r) begin
                  res_status_r <= ST_NOMEM;
                  state_r      <= S_EMIT;
                end else begin
                  state_r <= S_ALLOC;
                end
              end
              KIND_FREE, KIND_CHECK: begin
                state_r <= S_LOC;
              end
              KIND_INIT: begin
                state_r <= S_IMOD;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        // pop: next link arrives from the RAM
        S_ALLOC: begin
          head_r       <= rd_link.idx;
          head_valid_r <= !rd_link.last;
          res_status_r <= ST_OK;
          res_addr_r   <= pool_base_r + ADDR_W'(prod_r);
          state_r      <= S_EMIT;
        end
        S_LOC: begin
          if (bad_span) begin
            res_status_r <= ST_BADPTR;
            state_r      <= S_EMIT;
          end else begin
            rem_r   <= DW'(off_r);
            div_r   <= DW'(object_size_r) << (IW - 1);
            q_r     <= '0;
            cnt_r   <= BW'(IW - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          div_r <= div_r >> 1;
          q_r   <= q_shift[IW-1:0];
          if (cnt_r == '0) begin
            state_r <= S_DIVEND;
          end else begin
            cnt_r <= cnt_r - BW'(1);
          end
        end
        S_DIVEND: begin
          if (rem_r != '0) begin
            res_status_r <= ST_BADPTR;
            state_r      <= S_EMIT;
          end else if (kind_r == KIND_FREE) begin
            head_r       <= q_r;
            head_valid_r <= 1'b1;
            res_status_r <= ST_OK;
            state_r      <= S_EMIT;
          end else begin
            cur_r   <= head_r;
            live_r  <= head_valid_r;
            steps_r <= '0;
            state_r <= S_WALK;
          end
        end
        // walk: end of list or step limit, then match, else follow link
        S_WALK: begin
          if (!live_r || (steps_r == CW'(MAX_OBJECTS))) begin
            res_status_r <= ST_OK;
            state_r      <= S_EMIT;
          end else if (cur_r == q_r) begin
            res_status_r <= ST_FREE;
            state_r      <= S_EMIT;
          end else begin
            steps_r <= steps_r + CW'(1);
            state_r <= S_WSTEP;
          end
        end
        S_WSTEP: begin
          cur_r   <= rd_link.idx;
          live_r  <= !rd_link.last;
          state_r <= S_WALK;
        end
        S_IMOD: begin
          if (size_res != '0) begin
            res_status_r <= ST_SIZE;
            state_r      <= S_EMIT;
          end else if (eff_cnt == '0) begin
            head_r       <= '0;
            head_valid_r <= 1'b0;
            res_status_r <= ST_OK;
            state_r      <= S_EMIT;
          end else begin
            fill_r  <= '0;
            state_r <= S_IFILL;
          end
        end
        S_IFILL: begin
          if (fill_last) begin
            head_r       <= '0;
            head_valid_r <= 1'b1;
            res_status_r <= ST_OK;
            state_r      <= S_EMIT;
          end else begin
            fill_r <= fill_inc;
          end
        end
        // hand the result to the output register once it is free
        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // assertions
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted request did not start work");

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result loaded outside the emit step");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVEND) |-> (rem_r < DW'(object_size_r)))
    else $error("divider remainder not below object size");

  a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("list RAM read and written in the same cycle");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WSTEP) |-> ((steps_r <= CW'(MAX_OBJECTS)) && $past(ram_re)))
    else $error("list walk step without a RAM read or past its bound");

endmodule

[dv/fpfl_checker.sv]
`timescale 1ns / 100ps
// Result checker for the pool allocator: watches request, result and register beats,
// keeps its own copy of the free list and compares every result in order.
// Depends on fpfl_pkg, fpfl_req_if and fpfl_rsp_if.
module fpfl_checker import fpfl_pkg::*; #(
  parameter int MAX_OBJECTS = 1024,
  parameter int ENTRY_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  fpfl_req_if               req,
  fpfl_rsp_if               rsp,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                fail_count,
  output int                answers_owed
);

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] object_address;
  } answer_t;

  // shadow registers
  logic [ADDR_W-1:0] pool_base;
  logic [SIZE_W-1:0] obj_size;
  logic [CNT_W-1:0]  obj_count;

  // shadow free list
  logic [CNT_W-1:0]  link     [MAX_OBJECTS];
  logic              link_end [MAX_OBJECTS];
  logic [CNT_W-1:0]  top;
  logic              top_valid;

  answer_t answers_due[$];

  // object count after clamping to the list memory depth
  function automatic int unsigned usable_count();
    return (obj_count > MAX_OBJECTS) ? MAX_OBJECTS : obj_count;
  endfunction

  // address -> entry index, false unless it is the start of an object in the pool
  function automatic bit find_slot(input logic [ADDR_W-1:0] a, output int unsigned slot);
    logic [63:0]       span;
    logic [ADDR_W-1:0] off;
    span = 64'(obj_size) * 64'(usable_count());
    slot = 0;
    if (obj_size == '0 || a < pool_base) return 1'b0;
    off = a - pool_base;
    if (64'(off) >= span || (off % obj_size) != 0) return 1'b0;
    slot = off / obj_size;
    return slot < MAX_OBJECTS;
  endfunction

  // result of one request, updating the shadow list
  function automatic answer_t pool_answer(input kind_t kind, input logic [SIZE_W-1:0] rsz,
                                          input logic [ADDR_W-1:0] a);
    answer_t          ans;
    int unsigned      slot;
    int unsigned      n;
    int unsigned      steps;
    logic [CNT_W-1:0] cur;
    logic             live;
    ans.status         = ST_OK;
    ans.object_address = '0;
    case (kind)
      KIND_ALLOC: begin
        // size mismatch wins over an empty list
        if (rsz != obj_size) ans.status = ST_SIZE;
        else if (!top_valid) ans.status = ST_NOMEM;
        else begin
          ans.object_address = pool_base + ADDR_W'(top) * ADDR_W'(obj_size);
          top_valid = !link_end[top];
          top       = link[top];
        end
      end
      KIND_FREE: begin
        // no double free detection: a repeated push may close a loop
        if (!find_slot(a, slot)) ans.status = ST_BADPTR;
        else begin
          link[slot]     = top;
          link_end[slot] = !top_valid;
          top            = CNT_W'(slot);
          top_valid      = 1'b1;
        end
      end
      KIND_CHECK: begin
        if (!find_slot(a, slot)) ans.status = ST_BADPTR;
        else begin
          // bounded walk, a looped list ends after MAX_OBJECTS steps as not free
          cur  = top;
          live = top_valid;
          for (steps = 0; live && steps < MAX_OBJECTS && ans.status == ST_OK; steps++) begin
            if (cur == CNT_W'(slot)) ans.status = ST_FREE;
            else begin
              live = !link_end[cur];
              cur  = link[cur];
            end
          end
        end
      end
      default: begin
        if ((obj_size % ENTRY_BYTES) != 0) ans.status = ST_SIZE;
        else begin
          n = usable_count();
          for (int unsigned i = 0; i < n; i++) begin
            link[i]     = CNT_W'(i + 1);
            link_end[i] = (i + 1 == n);
          end
          top       = '0;
          top_valid = (n != 0);
        end
      end
    endcase
    return ans;
  endfunction

  // beat monitor: register writes, result compare, request prediction
  always @(posedge clk) begin : monitor
    answer_t seen;
    answer_t want;
    if (!rst_n) begin
      pool_base = '0;
      obj_size  = SIZE_W'(4);
      obj_count = CNT_W'(1024);
      for (int i = 0; i < MAX_OBJECTS; i++) begin
        link[i]     = '0;
        link_end[i] = 1'b1;
      end
      top       = '0;
      top_valid = 1'b0;
      answers_due.delete();
      fail_count   <= 0;
      answers_owed <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_POOL_BASE:   pool_base = cfg_pwdata[ADDR_W-1:0];
          REG_OBJECT_SIZE: obj_size  = cfg_pwdata[SIZE_W-1:0];
          REG_NUM_OBJECTS: obj_count = cfg_pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // result beats are matched before this edge's request is predicted
      if (rsp.valid && rsp.ready) begin
        seen.status         = rsp.status;
        seen.object_address = rsp.object_address;
        if (answers_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: status %0d addr %h", seen.status,
                     seen.object_address);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_due.pop_front();
          if (want !== seen) begin
            if (fail_count < 10)
              $display("result mismatch: expected status %0d addr %h, got status %0d addr %h",
                       want.status, want.object_address, seen.status, seen.object_address);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (req.valid && req.ready)
        answers_due.push_back(pool_answer(req.kind, req.request_size, req.address));
      answers_owed <= answers_due.size();
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Top of the pool allocator bench: clock, reset, register setup and request traffic,
// verdict from the checker. Depends on fpfl_pkg, the channel interfaces, the block, fpfl_checker.
module tb;
  import fpfl_pkg::*;

  localparam int MAX_OBJECTS = 1024;
  localparam int ENTRY_BYTES = 4;
  localparam int QUIET_LIMIT = 20000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                answers_owed;

  fpfl_req_if req_ch ();
  fpfl_rsp_if rsp_ch ();

  fixed_pool_free_list_allocator #(
    .MAX_OBJECTS(MAX_OBJECTS),
    .ENTRY_BYTES(ENTRY_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (req_ch),
    .out_rsp    (rsp_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  fpfl_checker #(
    .MAX_OBJECTS(MAX_OBJECTS),
    .ENTRY_BYTES(ENTRY_BYTES)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .answers_owed(answers_owed)
  );

  // current setting, used to aim addresses at real objects
  logic [ADDR_W-1:0] cur_base;
  logic [SIZE_W-1:0] cur_size;
  logic [CNT_W-1:0]  cur_count;
  logic [ADDR_W-1:0] granted[$];
  kind_t             in_flight[$];
  bit                send_steady;
  bit                take_steady;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // collect allocated addresses; sampled mid-cycle so the next edge's beats are seen
  always @(negedge clk) begin
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready && in_flight.size() > 0) begin
        if (in_flight.pop_front() == KIND_ALLOC && rsp_ch.status == ST_OK)
          granted.push_back(rsp_ch.object_address);
      end
      if (req_ch.valid && req_ch.ready) in_flight.push_back(req_ch.kind);
    end
  end

  // one register write: setup then access
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic configure(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                           input logic [CNT_W-1:0] count);
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_OBJECT_SIZE, CFG_DW'(size));
    write_reg(REG_NUM_OBJECTS, CFG_DW'(count));
    cur_base  = base;
    cur_size  = size;
    cur_count = count;
    granted.delete();
  endtask

  // one request beat, after a random gap; valid stays high into a back-to-back beat
  task automatic send_req(input kind_t kind, input logic [SIZE_W-1:0] rsz,
                          input logic [ADDR_W-1:0] a);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.request_size <= rsz;
    req_ch.address      <= a;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind == KIND_INIT) granted.delete();
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly well-aimed traffic: matching sizes, allocated or in-pool addresses
  task automatic random_request();
    int                pick;
    int                eff;
    int                slot;
    logic [ADDR_W-1:0] a;
    logic [SIZE_W-1:0] rsz;
    kind_t             kind;
    eff  = (cur_count > MAX_OBJECTS) ? MAX_OBJECTS : cur_count;
    pick = $urandom_range(0, 99);
    rsz  = ($urandom_range(0, 99) < 85) ? cur_size : SIZE_W'($urandom);
    a    = $urandom;
    if (pick < 36) kind = KIND_ALLOC;
    else if (pick < 66) kind = KIND_FREE;
    else if (pick < 93) kind = KIND_CHECK;
    else kind = KIND_INIT;
    if (kind == KIND_FREE || kind == KIND_CHECK) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 && granted.size() > 0) begin
        slot = $urandom_range(0, granted.size() - 1);
        a    = granted[slot];
        if (kind == KIND_FREE) granted.delete(slot);
      end else if (pick < 80) begin
        a = cur_base + ADDR_W'($urandom_range(0, eff + 1)) * ADDR_W'(cur_size);
      end else if (pick < 88) begin
        a = cur_base + ADDR_W'($urandom_range(0, eff)) * ADDR_W'(cur_size)
            + ADDR_W'($urandom_range(1, 3));
      end else if (pick < 94) begin
        a = cur_base - ADDR_W'($urandom_range(1, 16));
      end
    end
    send_req(kind, rsz, a);
  endtask

  // hand-picked corner cases
  task automatic directed_phase(input int ph);
    case (ph)
      0: begin
        configure(32'h0000_1000, 16'd12, 11'd3);
        send_req(KIND_ALLOC, 16'd12, '0);              // list empty after reset
        send_req(KIND_CHECK, '0, 32'h0000_1000);       // empty list, not free
        send_req(KIND_INIT, '0, '0);
        send_req(KIND_ALLOC, 16'h0000, '0);            // wrong size
        repeat (3) send_req(KIND_ALLOC, 16'd12, '0);
        send_req(KIND_ALLOC, 16'hFFFF, '0);            // size beats empty
        send_req(KIND_ALLOC, 16'd12, '0);              // out of objects
        send_req(KIND_FREE, '0, 32'h0000_1000);
        send_req(KIND_FREE, '0, 32'h0000_1001);        // off boundary
        send_req(KIND_FREE, '0, 32'h0000_0FFF);        // below pool
        send_req(KIND_FREE, '0, 32'h0000_1024);        // past last object
        send_req(KIND_CHECK, '0, 32'h0000_1000);       // free
        send_req(KIND_FREE, '0, 32'h0000_1000);        // double free loops the list
        send_req(KIND_CHECK, '0, 32'h0000_100C);       // walk runs out, not free
      end
      1: begin
        configure(32'h2000_0000, 16'd6, 11'd2);
        send_req(KIND_INIT, '0, '0);                   // size not a word multiple
      end
      2: begin
        configure(32'h0000_0040, 16'd0, 11'd5);
        send_req(KIND_FREE, '0, 32'h0000_0040);        // zero size, no valid address
        send_req(KIND_INIT, '0, '0);
        send_req(KIND_ALLOC, 16'd0, '0);               // zero size allocate at base
      end
      3: begin
        configure(32'h0000_0000, 16'd8, 11'd0);
        send_req(KIND_INIT, '0, '0);                   // zero objects
        send_req(KIND_ALLOC, 16'd8, '0);
        send_req(KIND_CHECK, '0, 32'h0000_0000);
      end
      4: begin
        configure(32'h0000_0000, 16'd4, 11'h7FF);      // count clamped
        send_req(KIND_INIT, '0, '0);
        send_req(KIND_FREE, '0, 32'h0000_1000);        // index 1024, outside
        send_req(KIND_CHECK, '0, 32'h0000_0FFC);       // last entry of a full list
      end
      default: begin
        configure(32'hFFFF_FFF0, 16'd8, 11'd3);
        send_req(KIND_INIT, '0, '0);
        repeat (3) send_req(KIND_ALLOC, 16'd8, '0);    // third address wraps
        send_req(KIND_FREE, '0, 32'h0000_0000);        // wrapped address, below base
        send_req(KIND_FREE, '0, 32'hFFFF_FFFF);
      end
    endcase
  endtask

  // random traffic under one setting, opened by an init
  task automatic random_phase(input int ph);
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  count;
    int                items;
    base = $urandom;
    case (ph)
      0: begin
        base  = base & ~32'h3;
        size  = 16'd4;
        count = 11'd16;
        items = 180;
      end
      1: begin
        size  = SIZE_W'(4 * $urandom_range(1, 16));
        count = CNT_W'($urandom_range(1, 32));
        items = 180;
      end
      2: begin
        size  = SIZE_W'($urandom);
        count = CNT_W'($urandom_range(1, 40));
        items = 120;
      end
      3: begin
        base  = 32'hFFFF_FFFF;
        size  = 16'd4;
        count = 11'd4;
        items = 80;
      end
      4: begin
        size  = 16'd65532;
        count = 11'd8;
        items = 80;
      end
      5: begin
        base  = 32'h0000_0000;
        size  = 16'd4;
        count = 11'd1024;
        items = 60;
      end
      6: begin
        size  = SIZE_W'(4 * $urandom_range(1, 64));
        count = 11'h7FF;
        items = 40;
      end
      7: begin
        size  = 16'd0;
        count = 11'd10;
        items = 60;
      end
      8: begin
        size  = SIZE_W'(4 * $urandom_range(1, 8));
        count = 11'd1;
        items = 100;
      end
      default: begin
        size  = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom)
                                             : SIZE_W'(4 * $urandom_range(1, 32));
        count = CNT_W'($urandom_range(0, 64));
        items = 150;
      end
    endcase
    configure(base, size, count);
    send_req(KIND_INIT, SIZE_W'($urandom), $urandom);
    repeat (items - 1) random_request();
  endtask

  // result side: random ready gaps per beat, with stretches of none
  initial begin : result_sink
    int gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
      gap = take_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // watchdog: too long without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // reset, directed corners, random phases, verdict
  initial begin : stimulus
    rst_n               <= 1'b0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.kind         <= KIND_ALLOC;
    req_ch.request_size <= '0;
    req_ch.address      <= '0;
    cur_base  = '0;
    cur_size  = SIZE_W'(4);
    cur_count = CNT_W'(1024);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      directed_phase(ph);
      settle();
    end
    for (int ph = 0; ph < 10; ph++) begin
      random_phase(ph);
      settle();
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && answers_owed == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
rtl/fpfl_pkg.sv
rtl/fpfl_req_if.sv
rtl/fpfl_rsp_if.sv
rtl/fpfl_ram.sv
rtl/fixed_pool_free_list_allocator.sv
dv/fpfl_checker.sv
dv/tb.sv
